/* hdl/grid_field_bilinear_sampler_core_macros.svh */
// Assertion macros used by the grid sampler checker.
`ifndef GRID_FIELD_BILINEAR_SAMPLER_CORE_MACROS_SVH
`define GRID_FIELD_BILINEAR_SAMPLER_CORE_MACROS_SVH

// Clocked on clk_i, switched off while rst_ni is low.
`define GFBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked on clk_i, also checked while reset is applied.
`define GFBS_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hdl/gfbs_pkg.sv */
// Types and constants of the grid field bilinear sampler.
package gfbs_pkg;

  typedef logic signed [31:0] q16_t;
  typedef logic [8:0]         coord_t;
  typedef logic [8:0]         dim_t;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_READ   = 2'd1,
    OP_SAMPLE = 2'd2,
    OP_NONE   = 2'd3
  } gfbs_op_e;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_INV_CELL = 3'd2;
  localparam logic [2:0] REG_GRID_W   = 3'd3;
  localparam logic [2:0] REG_GRID_H   = 3'd4;

  localparam q16_t        CELL_RESET = 32'sh7FFF_FFFF;
  localparam q16_t        Q16_MAX    = 32'sh7FFF_FFFF;
  localparam q16_t        Q16_MIN    = 32'sh8000_0000;
  localparam logic [31:0] INV_RESET  = 32'h0001_0000;
  localparam dim_t        DIM_RESET  = 9'd256;
  localparam logic [16:0] FRAC_ONE   = 17'h1_0000;

endpackage

/* hdl/gfbs_if.sv */
// Request and response channel interfaces of the grid sampler.
interface gfbs_req_if;
  import gfbs_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] operation;
  coord_t     cell_col;
  coord_t     cell_row;
  q16_t       cell_value;
  q16_t       point_x;
  q16_t       point_y;

  modport source (
    output valid, operation, cell_col, cell_row, cell_value, point_x, point_y,
    input  ready
  );
  modport sink (
    input  valid, operation, cell_col, cell_row, cell_value, point_x, point_y,
    output ready
  );
endinterface

interface gfbs_rsp_if;
  import gfbs_pkg::*;

  logic valid;
  logic ready;
  q16_t distance;
  q16_t grad_x;
  q16_t grad_y;

  modport source (output valid, distance, grad_x, grad_y, input ready);
  modport sink (input valid, distance, grad_x, grad_y, output ready);
endinterface

/* hdl/gfbs_ram.sv */
// Single-port synchronous RAM with registered read.
module gfbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/grid_field_bilinear_sampler_core.sv */
// Signed distance grid in Q16.16 with cell write, cell read and bilinear sampling
// with gradient. After reset the grid is swept to the largest positive value, one
// cell a cycle, and no request beat is taken during that pass (register writes
// are). One item is in work at a time. A sample makes four reads from the
// single-port grid memory and uses the one shared 34x34 multiplier for the
// mapping, the weights, the distance, both slopes and both gradient scalings in
// turn. A finished result sits in the output register while the next item is
// taken.
module grid_field_bilinear_sampler_core #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  gfbs_req_if.sink                  req,
  gfbs_rsp_if.source                rsp,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [gfbs_pkg::CFG_AW-1:0] paddr,
  input  logic [gfbs_pkg::CFG_DW-1:0] pwdata,
  output logic [gfbs_pkg::CFG_DW-1:0] prdata,
  output logic                      pready
);
  import gfbs_pkg::*;

  localparam int CW    = $clog2(MAX_COLS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int MW    = (CW > RW) ? CW : RW;
  localparam int EW0   = (CW > RW) ? CW + 1 : RW + 1;
  localparam int EW    = (EW0 > 9) ? EW0 : 9;
  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [2:0] ST_CLEAR     = 3'd0;
  localparam logic [2:0] ST_IDLE      = 3'd1;
  localparam logic [2:0] ST_WRITE     = 3'd2;
  localparam logic [2:0] ST_READ      = 3'd3;
  localparam logic [2:0] ST_READ_WAIT = 3'd4;
  localparam logic [2:0] ST_SAMPLE    = 3'd5;
  localparam logic [2:0] ST_OUT       = 3'd6;

  // sample sequencer steps
  localparam logic [4:0] SP_MAP_X  = 5'd0;
  localparam logic [4:0] SP_MAP_Y  = 5'd1;
  localparam logic [4:0] SP_CELL_Y = 5'd2;
  localparam logic [4:0] SP_RD00   = 5'd3;
  localparam logic [4:0] SP_RD10   = 5'd4;
  localparam logic [4:0] SP_RD01   = 5'd5;
  localparam logic [4:0] SP_RD11   = 5'd6;
  localparam logic [4:0] SP_GET11  = 5'd7;
  localparam logic [4:0] SP_ACC00  = 5'd8;
  localparam logic [4:0] SP_ACC10  = 5'd9;
  localparam logic [4:0] SP_ACC01  = 5'd10;
  localparam logic [4:0] SP_ACC11  = 5'd11;
  localparam logic [4:0] SP_DIST   = 5'd12;
  localparam logic [4:0] SP_SX1    = 5'd13;
  localparam logic [4:0] SP_SX     = 5'd14;
  localparam logic [4:0] SP_SY1    = 5'd15;
  localparam logic [4:0] SP_SY     = 5'd16;
  localparam logic [4:0] SP_GX     = 5'd17;
  localparam logic [4:0] SP_GY     = 5'd18;

  function automatic logic signed [49:0] rnd16(input logic signed [65:0] v);
    logic signed [65:0] t;
    t = v + (v[65] ? 66'sd32767 : 66'sd32768);
    return t[65:16];
  endfunction

  function automatic logic signed [33:0] rnd32(input logic signed [65:0] v);
    logic signed [65:0] t;
    t = v + (v[65] ? 66'sh7FFF_FFFF : 66'sh8000_0000);
    return t[65:32];
  endfunction

  function automatic q16_t sat32(input logic signed [49:0] v);
    if (v[49:31] == '0 || v[49:31] == '1) begin
      return v[31:0];
    end
    return v[49] ? Q16_MIN : Q16_MAX;
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                              input logic [CW-1:0] c);
    return AW'(r * MAX_COLS) + AW'(c);
  endfunction

  // configuration
  q16_t        ox_q, oy_q;
  logic [31:0] inv_q;
  dim_t        gw_q, gh_q;
  logic        cfg_wr;

  // control
  logic [2:0]    state_q, state_d;
  logic [4:0]    step_q, step_d;
  logic [AW-1:0] clr_q, clr_d;
  logic          out_valid_q, out_valid_d;
  logic          req_acc, slot_free;

  // captured item
  logic [8:0]         col_q, row_q;
  q16_t               val_q;
  logic signed [32:0] dx_q, dy_q;
  logic               inside_q;

  // sample datapath
  logic [CW-1:0]      cx_q;
  logic [RW-1:0]      cy_q;
  logic [16:0]        tx_q, ty_q, ax, by;
  q16_t               v00_q, v10_q, v01_q, v11_q;
  logic [32:0]        w00_q, w10_q, w01_q, w11_q;
  logic signed [32:0] dx0_q, dx1_q, dy0_q, dy1_q;
  logic signed [33:0] sx_q, sy_q;
  logic signed [65:0] prod_q, acc_q;
  logic signed [33:0] ma, mb;
  logic signed [67:0] mul_full;
  logic signed [49:0] acc_r16, prod_r16;
  logic signed [33:0] acc_r32;
  q16_t               res_dist_q, res_gx_q, res_gy_q;
  q16_t               out_dist_q, out_gx_q, out_gy_q;

  // effective grid size and bounds
  logic [EW-1:0] eff_w, eff_h, gw_ext, gh_ext, map_size;
  logic          in_inside;

  // axis mapping
  logic          map_neg;
  logic [31:0]   map_idx;
  logic [MW-1:0] map_cell;
  logic [16:0]   map_frac;

  // memory port
  logic          ram_we;
  logic [AW-1:0] ram_addr, base_addr;
  logic [31:0]   ram_wdata, ram_rdata;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign req_acc = req.valid && req.ready;
  assign req.ready = (state_q == ST_IDLE);
  assign slot_free = !out_valid_q || rsp.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ox_q  <= '0;
      oy_q  <= '0;
      inv_q <= INV_RESET;
      gw_q  <= DIM_RESET;
      gh_q  <= DIM_RESET;
    end else if (cfg_wr) begin
      case (paddr[CFG_AW-1:2])
        REG_ORIGIN_X: ox_q  <= pwdata;
        REG_ORIGIN_Y: oy_q  <= pwdata;
        REG_INV_CELL: inv_q <= pwdata;
        REG_GRID_W:   gw_q  <= pwdata[8:0];
        REG_GRID_H:   gh_q  <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[CFG_AW-1:2])
      REG_ORIGIN_X: prdata = ox_q;
      REG_ORIGIN_Y: prdata = oy_q;
      REG_INV_CELL: prdata = inv_q;
      REG_GRID_W:   prdata = {23'b0, gw_q};
      REG_GRID_H:   prdata = {23'b0, gh_q};
      default:      prdata = '0;
    endcase
  end

  always_comb begin
    gw_ext = EW'(gw_q);
    gh_ext = EW'(gh_q);
    if (gw_ext < EW'(2)) begin
      eff_w = EW'(2);
    end else if (gw_ext > EW'(MAX_COLS)) begin
      eff_w = EW'(MAX_COLS);
    end else begin
      eff_w = gw_ext;
    end
    if (gh_ext < EW'(2)) begin
      eff_h = EW'(2);
    end else if (gh_ext > EW'(MAX_ROWS)) begin
      eff_h = EW'(MAX_ROWS);
    end else begin
      eff_h = gh_ext;
    end
  end

  assign in_inside = (EW'(req.cell_col) < eff_w) && (EW'(req.cell_row) < eff_h);

  // control path
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    clr_d   = clr_q;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_acc) begin
          step_d = '0;
          case (req.operation)
            OP_WRITE:  state_d = ST_WRITE;
            OP_READ:   state_d = ST_READ;
            OP_SAMPLE: state_d = ST_SAMPLE;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_WRITE:     state_d = ST_IDLE;
      ST_READ:      state_d = ST_READ_WAIT;
      ST_READ_WAIT: state_d = ST_OUT;
      ST_SAMPLE: begin
        step_d = step_q + 1'b1;
        if (step_q == SP_GY) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (state_q == ST_OUT && slot_free) begin
      out_valid_d = 1'b1;
    end else if (rsp.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      step_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // grid memory
  assign base_addr = cell_addr(cy_q, cx_q);

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = cell_addr(RW'(row_q), CW'(col_q));
    ram_wdata = val_q;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = CELL_RESET;
      end
      ST_WRITE: ram_we = inside_q;
      ST_SAMPLE: begin
        case (step_q)
          SP_RD00: ram_addr = base_addr;
          SP_RD10: ram_addr = base_addr + AW'(1);
          SP_RD01: ram_addr = base_addr + AW'(MAX_COLS);
          SP_RD11: ram_addr = base_addr + AW'(MAX_COLS + 1);
          default: ram_addr = base_addr;
        endcase
      end
      default: ;
    endcase
  end

  gfbs_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // shared multiplier, one product per step
  assign ax = 17'(FRAC_ONE - tx_q);
  assign by = 17'(FRAC_ONE - ty_q);

  always_comb begin
    ma = '0;
    mb = '0;
    case (step_q)
      SP_MAP_X: begin ma = 34'(dx_q);  mb = {2'b0, inv_q}; end
      SP_MAP_Y: begin ma = 34'(dy_q);  mb = {2'b0, inv_q}; end
      SP_RD00:  begin ma = {17'b0, ax};   mb = {17'b0, by};   end
      SP_RD10:  begin ma = {17'b0, tx_q}; mb = {17'b0, by};   end
      SP_RD01:  begin ma = {17'b0, ax};   mb = {17'b0, ty_q}; end
      SP_RD11:  begin ma = {17'b0, tx_q}; mb = {17'b0, ty_q}; end
      SP_GET11: begin ma = 34'(v00_q); mb = {1'b0, w00_q}; end
      SP_ACC00: begin ma = 34'(v10_q); mb = {1'b0, w10_q}; end
      SP_ACC10: begin ma = 34'(v01_q); mb = {1'b0, w01_q}; end
      SP_ACC01: begin ma = 34'(v11_q); mb = {1'b0, w11_q}; end
      SP_ACC11: begin ma = 34'(dx0_q); mb = {17'b0, by};   end
      SP_DIST:  begin ma = 34'(dx1_q); mb = {17'b0, ty_q}; end
      SP_SX1:   begin ma = 34'(dy0_q); mb = {17'b0, ax};   end
      SP_SX:    begin ma = 34'(dy1_q); mb = {17'b0, tx_q}; end
      SP_SY:    begin ma = sx_q;       mb = {2'b0, inv_q}; end
      SP_GX:    begin ma = sy_q;       mb = {2'b0, inv_q}; end
      default: ;
    endcase
  end

  assign mul_full = ma * mb;
  assign acc_r16  = rnd16(acc_q);
  assign acc_r32  = rnd32(acc_q);
  assign prod_r16 = rnd16(prod_q);

  // point to cell: negative lands on cell 0, past the last cell clamps to fraction 1.0
  assign map_size = (step_q == SP_CELL_Y) ? eff_h : eff_w;
  assign map_neg  = prod_q[65];
  assign map_idx  = prod_q[63:32];

  always_comb begin
    if (map_neg) begin
      map_cell = '0;
      map_frac = '0;
    end else if (map_idx >= 32'(map_size) - 32'd1) begin
      map_cell = MW'(map_size - EW'(2));
      map_frac = FRAC_ONE;
    end else begin
      map_cell = MW'(map_idx);
      map_frac = {1'b0, prod_q[31:16]};
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_full[65:0];
    if (req_acc) begin
      col_q    <= req.cell_col;
      row_q    <= req.cell_row;
      val_q    <= req.cell_value;
      dx_q     <= 33'(req.point_x) - 33'(ox_q);
      dy_q     <= 33'(req.point_y) - 33'(oy_q);
      inside_q <= in_inside;
    end
    if (state_q == ST_READ_WAIT) begin
      res_dist_q <= inside_q ? ram_rdata : '0;
      res_gx_q   <= '0;
      res_gy_q   <= '0;
    end
    if (state_q == ST_SAMPLE) begin
      case (step_q)
        SP_MAP_Y: begin
          cx_q <= CW'(map_cell);
          tx_q <= map_frac;
        end
        SP_CELL_Y: begin
          cy_q <= RW'(map_cell);
          ty_q <= map_frac;
        end
        SP_RD10: begin v00_q <= ram_rdata; w00_q <= prod_q[32:0]; end
        SP_RD01: begin v10_q <= ram_rdata; w10_q <= prod_q[32:0]; end
        SP_RD11: begin v01_q <= ram_rdata; w01_q <= prod_q[32:0]; end
        SP_GET11: begin v11_q <= ram_rdata; w11_q <= prod_q[32:0]; end
        SP_ACC00: begin
          acc_q <= prod_q;
          dx0_q <= 33'(v10_q) - 33'(v00_q);
          dx1_q <= 33'(v11_q) - 33'(v01_q);
          dy0_q <= 33'(v01_q) - 33'(v00_q);
          dy1_q <= 33'(v11_q) - 33'(v10_q);
        end
        SP_ACC10, SP_ACC01, SP_ACC11, SP_SX1, SP_SY1: acc_q <= acc_q + prod_q;
        SP_DIST: begin
          res_dist_q <= sat32(50'(acc_r32));
          acc_q      <= prod_q;
        end
        SP_SX: begin
          sx_q  <= acc_r16[33:0];
          acc_q <= prod_q;
        end
        SP_SY: sy_q     <= acc_r16[33:0];
        SP_GX: res_gx_q <= sat32(prod_r16);
        SP_GY: res_gy_q <= sat32(prod_r16);
        default: ;
      endcase
    end
    if (state_q == ST_OUT && slot_free) begin
      out_dist_q <= res_dist_q;
      out_gx_q   <= res_gx_q;
      out_gy_q   <= res_gy_q;
    end
  end

  assign rsp.valid    = out_valid_q;
  assign rsp.distance = out_dist_q;
  assign rsp.grad_x   = out_gx_q;
  assign rsp.grad_y   = out_gy_q;

endmodule

/* hdl/gfbs_checker.sv */
// Port-level assertions for the grid sampler, bound to the top level.
`include "grid_field_bilinear_sampler_core_macros.svh"

module gfbs_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        req_valid_i,
  input logic                        req_ready_i,
  input logic [1:0]                  req_operation_i,
  input logic                        rsp_valid_i,
  input logic                        rsp_ready_i,
  input gfbs_pkg::q16_t              rsp_distance_i,
  input gfbs_pkg::q16_t              rsp_grad_x_i,
  input gfbs_pkg::q16_t              rsp_grad_y_i,
  input logic                        psel_i,
  input logic                        penable_i,
  input logic                        pwrite_i,
  input logic [gfbs_pkg::CFG_AW-1:0] paddr_i,
  input logic [gfbs_pkg::CFG_DW-1:0] pwdata_i,
  input logic [gfbs_pkg::CFG_DW-1:0] prdata_i
);
  import gfbs_pkg::*;

  logic inv_wr, inv_rd;

  assign inv_wr = psel_i && penable_i && pwrite_i && (paddr_i[CFG_AW-1:2] == REG_INV_CELL);
  assign inv_rd = psel_i && !pwrite_i && (paddr_i[CFG_AW-1:2] == REG_INV_CELL);

  // the grid sweep after reset keeps the request side closed
  `GFBS_ASSERT_ANY(a_clear_blocks_req, !rst_ni |=> !req_ready_i, "request taken during grid clear")

  // one item in work at a time
  `GFBS_ASSERT(a_one_in_work, req_valid_i && req_ready_i && req_operation_i != OP_NONE |=> !req_ready_i, "second item taken while busy")

  `GFBS_ASSERT(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_distance_i) && $stable(rsp_grad_x_i) && $stable(rsp_grad_y_i), "stalled result beat changed")

  `GFBS_ASSERT(a_inv_readback, inv_rd && $past(inv_wr) && $past(rst_ni) |-> prdata_i == $past(pwdata_i), "scale register read back wrong")

endmodule

bind grid_field_bilinear_sampler_core gfbs_checker u_gfbs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req.valid),
  .req_ready_i     (req.ready),
  .req_operation_i (req.operation),
  .rsp_valid_i     (rsp.valid),
  .rsp_ready_i     (rsp.ready),
  .rsp_distance_i  (rsp.distance),
  .rsp_grad_x_i    (rsp.grad_x),
  .rsp_grad_y_i    (rsp.grad_y),
  .psel_i          (psel),
  .penable_i       (penable),
  .pwrite_i        (pwrite),
  .paddr_i         (paddr),
  .pwdata_i        (pwdata),
  .prdata_i        (prdata)
);

/* sim/gfbs_tb_pkg.sv */
// Scoreboard and bit-exact grid sampler prediction for the grid sampler testbench.
`timescale 1ns / 1ps
package gfbs_tb_pkg;
  import gfbs_pkg::*;

  localparam int GRID_COLS = 256;
  localparam int GRID_ROWS = 256;

  typedef struct {
    gfbs_op_e op;
    coord_t   col;
    coord_t   row;
    q16_t     value;
    q16_t     px;
    q16_t     py;
  } field_req_t;

  typedef struct {
    q16_t distance;
    q16_t grad_x;
    q16_t grad_y;
  } field_result_t;

  function automatic q16_t clamp_q16(longint v);
    if (v > longint'(Q16_MAX)) return Q16_MAX;
    if (v < longint'(Q16_MIN)) return Q16_MIN;
    return q16_t'(v);
  endfunction

  class field_scoreboard;
    q16_t           org_x;
    q16_t           org_y;
    logic [31:0]    inv_cell;
    dim_t           grid_w;
    dim_t           grid_h;
    int             mismatches;
    int             grid_cells[GRID_COLS * GRID_ROWS];
    field_result_t  results_due[$];

    function new();
      foreach (grid_cells[i]) grid_cells[i] = CELL_RESET;
      org_x      = '0;
      org_y      = '0;
      inv_cell   = INV_RESET;
      grid_w     = DIM_RESET;
      grid_h     = DIM_RESET;
      mismatches = 0;
    endfunction

    function int unsigned clamp_dim(dim_t d, int unsigned maxv);
      if (d < 2) return 2;
      if (d > maxv) return maxv;
      return d;
    endfunction

    function int unsigned cols_in_use();
      return clamp_dim(grid_w, GRID_COLS);
    endfunction

    function int unsigned rows_in_use();
      return clamp_dim(grid_h, GRID_ROWS);
    endfunction

    function int pending();
      return results_due.size();
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        REG_ORIGIN_X: org_x = v;
        REG_ORIGIN_Y: org_y = v;
        REG_INV_CELL: inv_cell = v;
        REG_GRID_W:   grid_w = v[8:0];
        REG_GRID_H:   grid_h = v[8:0];
        default: ;
      endcase
    endfunction

    // Shift right with rounding half away from zero.
    function longint round_away(longint v, int sh);
      longint unsigned m;
      if (v < 0) m = 64'd0 - longint'(v);
      else m = v;
      m = (m + (64'd1 << (sh - 1))) >> sh;
      if (v < 0) return -longint'(m);
      return longint'(m);
    endfunction

    // World point to grid cell and fraction with 16 fractional bits, clamped at both edges.
    function void locate_axis(q16_t p, q16_t org, int unsigned size,
                              output int unsigned cell_idx, output longint frac);
      longint          d;
      longint unsigned mag;
      longint unsigned m;
      longint unsigned idx;
      d = longint'(p) - longint'(org);
      if (d < 0) mag = -d;
      else mag = d;
      m = mag * {32'd0, inv_cell};
      if (d < 0 && m != 0) begin
        cell_idx = 0;
        frac     = 0;
        return;
      end
      idx  = m >> 32;
      frac = longint'((m >> 16) & 64'hFFFF);
      if (idx >= size - 1) begin
        cell_idx = size - 2;
        frac     = 65536;
        return;
      end
      cell_idx = idx;
    endfunction

    // Grid-unit slope to world units, rounded then saturated.
    function q16_t scale_slope(longint slope);
      longint unsigned mag;
      longint unsigned p;
      if (slope < 0) mag = 64'd0 - longint'(slope);
      else mag = slope;
      p = mag * {32'd0, inv_cell};
      p = (p >> 16) + ((p >> 15) & 64'd1);
      if (slope < 0) return (p > 64'h8000_0000) ? Q16_MIN : q16_t'(-longint'(p));
      return (p > 64'h7FFF_FFFF) ? Q16_MAX : q16_t'(p);
    endfunction

    function field_result_t sample_field(q16_t px, q16_t py);
      int unsigned   cx, cy, base;
      longint        tx, ty, v00, v10, v01, v11, v0, v1, dist_sum, sx, sy;
      field_result_t r;
      locate_axis(px, org_x, cols_in_use(), cx, tx);
      locate_axis(py, org_y, rows_in_use(), cy, ty);
      base     = cy * GRID_COLS + cx;
      v00      = grid_cells[base];
      v10      = grid_cells[base + 1];
      v01      = grid_cells[base + GRID_COLS];
      v11      = grid_cells[base + GRID_COLS + 1];
      v0       = v00 * (65536 - tx) + v10 * tx;
      v1       = v01 * (65536 - tx) + v11 * tx;
      dist_sum = v0 * (65536 - ty) + v1 * ty;
      sx       = round_away((65536 - ty) * (v10 - v00) + ty * (v11 - v01), 16);
      sy       = round_away((65536 - tx) * (v01 - v00) + tx * (v11 - v10), 16);
      r.distance = clamp_q16(round_away(dist_sum, 32));
      r.grad_x   = scale_slope(sx);
      r.grad_y   = scale_slope(sy);
      return r;
    endfunction

    function void note_request(field_req_t it);
      int unsigned   idx;
      bit            in_grid;
      field_result_t r;
      in_grid = (it.col < cols_in_use()) && (it.row < rows_in_use());
      idx     = it.row * GRID_COLS + it.col;
      case (it.op)
        OP_WRITE: begin
          if (in_grid) grid_cells[idx] = it.value;
        end
        OP_READ: begin
          r.distance = in_grid ? q16_t'(grid_cells[idx]) : '0;
          r.grad_x   = '0;
          r.grad_y   = '0;
          results_due.push_back(r);
        end
        OP_SAMPLE: begin
          results_due.push_back(sample_field(it.px, it.py));
        end
        default: ;
      endcase
    endfunction

    function void check_result(q16_t distance, q16_t grad_x, q16_t grad_y);
      field_result_t want;
      if (results_due.size() == 0) begin
        $error("result beat with nothing outstanding: distance %0d", distance);
        mismatches++;
        return;
      end
      want = results_due.pop_front();
      if (distance !== want.distance) begin
        $error("distance: expected %0d, got %0d", want.distance, distance);
        mismatches++;
      end
      if (grad_x !== want.grad_x) begin
        $error("grad_x: expected %0d, got %0d", want.grad_x, grad_x);
        mismatches++;
      end
      if (grad_y !== want.grad_y) begin
        $error("grad_y: expected %0d, got %0d", want.grad_y, grad_y);
        mismatches++;
      end
    endfunction
  endclass

endpackage

/* sim/tb_top.sv */
// Top-level testbench of the grid field bilinear sampler: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_top;
  import gfbs_pkg::*;
  import gfbs_tb_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 32;
  localparam int PHASE_ITEMS  = 225;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CFG_AW-1:0]   paddr;
  logic [CFG_DW-1:0]   pwdata;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;

  int                  src_idle_pct = 6;
  int                  snk_idle_pct = 70;
  int                  cycle_count;
  field_scoreboard     board;

  gfbs_req_if req_bus ();
  gfbs_rsp_if rsp_bus ();

  grid_field_bilinear_sampler_core #(
    .MAX_COLS (GRID_COLS),
    .MAX_ROWS (GRID_ROWS)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req     (req_bus),
    .rsp     (rsp_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog: covers the clearing sweep after reset plus the whole stimulus.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL grid_field_bilinear_sampler_core");
    $finish;
  end

  initial begin
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_bus.valid && rsp_bus.ready)
      board.check_result(rsp_bus.distance, rsp_bus.grad_x, rsp_bus.grad_y);
  end

  task automatic apb_write(logic [2:0] idx, logic [31:0] v);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    board.write_reg(idx, v);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_grid(q16_t ox, q16_t oy, logic [31:0] inv, dim_t w, dim_t h);
    apb_write(REG_ORIGIN_X, ox);
    apb_write(REG_ORIGIN_Y, oy);
    apb_write(REG_INV_CELL, inv);
    apb_write(REG_GRID_W, {23'd0, w});
    apb_write(REG_GRID_H, {23'd0, h});
  endtask

  // Holds the beat until taken; valid stays up for a back-to-back follower.
  task automatic send_item(field_req_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_bus.valid      <= 1'b1;
    req_bus.operation  <= it.op;
    req_bus.cell_col   <= it.col;
    req_bus.cell_row   <= it.row;
    req_bus.cell_value <= it.value;
    req_bus.point_x    <= it.px;
    req_bus.point_y    <= it.py;
    do @(posedge clk_i); while (!req_bus.ready);
    board.note_request(it);
  endtask

  // Writes give no result, so allow the block to finish one after the queue empties.
  task automatic drain_block();
    @(negedge clk_i);
    req_bus.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic field_req_t mk(gfbs_op_e op, int col, int row, q16_t v,
                                    q16_t px, q16_t py);
    field_req_t it;
    it.op    = op;
    it.col   = coord_t'(col);
    it.row   = coord_t'(row);
    it.value = v;
    it.px    = px;
    it.py    = py;
    return it;
  endfunction

  function automatic q16_t pick_value();
    case ($urandom_range(9))
      0:       return Q16_MAX;
      1:       return Q16_MIN;
      2, 3:    return q16_t'($urandom_range(2 ** 21)) - q16_t'(2 ** 20);
      default: return q16_t'($urandom());
    endcase
  endfunction

  // Mostly points from one cell outside to one cell past the far edge, in grid units.
  function automatic q16_t world_point(q16_t org, logic [31:0] inv, int unsigned span);
    longint g;
    if (inv == 0 || $urandom_range(3) == 0) return q16_t'($urandom());
    g = longint'($urandom_range((span + 2) * 65536)) - 65536;
    if ($urandom_range(3) == 0) g = (g >>> 16) <<< 16;
    return clamp_q16(longint'(org) + (g <<< 16) / longint'({32'd0, inv}));
  endfunction

  function automatic field_req_t random_item();
    field_req_t  it;
    int unsigned k, cols, rows, span_c, span_r;
    cols   = board.cols_in_use();
    rows   = board.rows_in_use();
    // half the time keep to a corner so samples see written cells
    span_c = ($urandom_range(1) != 0 || cols < 12) ? cols : 12;
    span_r = ($urandom_range(1) != 0 || rows < 12) ? rows : 12;
    k = $urandom_range(99);
    if (k < 35) it.op = OP_WRITE;
    else if (k < 60) it.op = OP_READ;
    else if (k < 95) it.op = OP_SAMPLE;
    else it.op = OP_NONE;
    it.col   = ($urandom_range(4) == 0) ? coord_t'($urandom_range(511))
                                        : coord_t'($urandom_range(span_c - 1));
    it.row   = ($urandom_range(4) == 0) ? coord_t'($urandom_range(511))
                                        : coord_t'($urandom_range(span_r - 1));
    it.value = pick_value();
    it.px    = world_point(board.org_x, board.inv_cell, span_c);
    it.py    = world_point(board.org_y, board.inv_cell, span_r);
    return it;
  endfunction

  initial begin
    board              = new();
    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    req_bus.valid      = 1'b0;
    req_bus.operation  = OP_NONE;
    req_bus.cell_col   = '0;
    req_bus.cell_row   = '0;
    req_bus.cell_value = '0;
    req_bus.point_x    = '0;
    req_bus.point_y    = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: fresh grid, extreme values, edge clamps and out-of-range cells.
    send_item(mk(OP_SAMPLE, 0, 0, 0, 0, 0));
    send_item(mk(OP_WRITE, 0, 0, Q16_MIN, 0, 0));
    send_item(mk(OP_WRITE, 1, 0, Q16_MAX, 0, 0));
    send_item(mk(OP_WRITE, 0, 1, 0, 0, 0));
    send_item(mk(OP_WRITE, 1, 1, q16_t'(-1), 0, 0));
    send_item(mk(OP_READ, 0, 0, 0, 0, 0));
    send_item(mk(OP_READ, 1, 1, 0, 0, 0));
    send_item(mk(OP_SAMPLE, 0, 0, 0, 32'sh0000_8000, 32'sh0000_8000));
    send_item(mk(OP_SAMPLE, 0, 0, 0, 32'sh0000_FFFF, 32'sh0000_0001));
    send_item(mk(OP_SAMPLE, 0, 0, 0, Q16_MIN, Q16_MIN));
    send_item(mk(OP_SAMPLE, 0, 0, 0, Q16_MAX, Q16_MAX));
    send_item(mk(OP_SAMPLE, 0, 0, 0, 32'sh00FF_0000, 32'sh00FE_0000));
    send_item(mk(OP_SAMPLE, 0, 0, 0, q16_t'(-1), 0));
    send_item(mk(OP_WRITE, 256, 3, 5, 0, 0));
    send_item(mk(OP_WRITE, 3, 300, 7, 0, 0));
    send_item(mk(OP_READ, 256, 3, 0, 0, 0));
    send_item(mk(OP_READ, 511, 511, 0, 0, 0));
    send_item(mk(OP_READ, 3, 3, 0, 0, 0));
    send_item(mk(OP_WRITE, 255, 255, 32'sh1234_5678, 0, 0));
    send_item(mk(OP_READ, 255, 255, 0, 0, 0));
    send_item(mk(OP_WRITE, 254, 255, q16_t'(-12345), 0, 0));
    send_item(mk(OP_SAMPLE, 0, 0, 0, 32'sh00FE_8000, 32'sh00FF_0000));
    send_item(mk(OP_NONE, 511, 511, Q16_MIN, Q16_MAX, Q16_MIN));

    for (int ph = 0; ph < 6; ph++) begin
      drain_block();
      if (ph < 2) begin
        src_idle_pct = 6;
        snk_idle_pct = 70;
      end else if (ph < 4) begin
        src_idle_pct = 70;
        snk_idle_pct = 6;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      case (ph)
        0: program_grid('0, '0, INV_RESET, 9'd8, 9'd8);
        1: program_grid(Q16_MIN, Q16_MAX, 32'hFFFF_FFFF, 9'd2, 9'd2);
        // zero scale, and sizes below the minimum
        2: program_grid(q16_t'($urandom_range(2 ** 20)), '0, '0, 9'd0, 9'd1);
        3: program_grid(q16_t'($urandom()), q16_t'($urandom()), 32'd1, 9'd511, 9'd257);
        4: program_grid(pick_value(), pick_value(), $urandom_range(32'h8_0000, 32'h2000),
                        dim_t'($urandom_range(24, 2)), dim_t'($urandom_range(24, 2)));
        default: program_grid(q16_t'($urandom()), q16_t'($urandom()), $urandom(),
                              dim_t'($urandom_range(511)), dim_t'($urandom_range(511)));
      endcase
      repeat (PHASE_ITEMS) send_item(random_item());
    end

    drain_block();
    if (board.mismatches == 0) $display("PASS grid_field_bilinear_sampler_core");
    else $display("FAIL grid_field_bilinear_sampler_core");
    $finish;
  end

endmodule
